FILE: rtl/core/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath handshake types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int NUM_COLS  = 80;
  localparam int NUM_ROWS  = 25;
  localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;

  // Field widths.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;
  localparam int ADDR_W = $clog2(NUM_CELLS);

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Character codes.
  localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [CHAR_W-1:0] TAB_CODE   = 8'h09;
  localparam logic [CHAR_W-1:0] CR_CODE    = 8'h0D;
  localparam logic [CHAR_W-1:0] LF_CODE    = 8'h0A;
  localparam int                TAB_STEP   = 4;

  // Reset value of the attribute register and of every cell of the clearing pass.
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'hF0;

  // Item function codes.
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input transfer
    logic clear_wr;  // write one blank cell of the post-reset clearing pass
    logic exec;      // carry out the captured item
    logic blank_wr;  // write one blank cell of the bottom row after a scroll
    logic out_load;  // load the result register
  } tcw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last cell
    logic blank_last;  // blanking sweep is at its last column
    logic is_read;     // captured item is a read
    logic scroll;      // captured put scrolls the screen
    logic out_free;    // result register can take a new result
  } tcw_sts_t;

endpackage

FILE: rtl/core/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/tcw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller: sequences the clearing pass, item execution, bottom-row
// blanking after a scroll and the hand-over of each result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_BLANK,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!sts.is_read && sts.scroll) begin
          state_nxt = S_BLANK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_BLANK: begin
        if (sts.blank_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands decoded from the current state.
  assign in_tready    = (state_r == S_IDLE);
  assign cmd.load     = (state_r == S_IDLE) && in_tvalid;
  assign cmd.clear_wr = (state_r == S_CLEAR);
  assign cmd.exec     = (state_r == S_EXEC);
  assign cmd.blank_wr = (state_r == S_BLANK);
  assign cmd.out_load = (state_r == S_OUT) && sts.out_free;

endmodule

FILE: rtl/core/tcw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath: screen store, cursor, scroll offset, address generation and
// the result register.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tcw_pkg::tcw_cmd_t                     cmd,
  output tcw_pkg::tcw_sts_t                     sts,
  input  logic [tcw_pkg::ATTR_W-1:0]            attr,
  input  logic [tcw_pkg::IN_DATA_W-1:0]         in_tdata,
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [tcw_pkg::OUT_DATA_W-1:0]        out_tdata
);
  import tcw_pkg::*;

  // Captured item.
  logic              func_r;
  logic [CHAR_W-1:0] char_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;

  // Cursor, scroll offset (physical row of the top screen row) and counters.
  logic [COL_W-1:0]  cur_x_r,   cur_x_nxt;
  logic [ROW_W-1:0]  cur_y_r,   cur_y_nxt;
  logic [ROW_W-1:0]  base_r,    base_nxt;
  logic              scroll_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [COL_W-1:0]  blank_cnt_r;

  // Result register.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Cursor arithmetic.
  logic [COL_W:0]   tab_sum;
  logic [COL_W:0]   nx;
  logic [ROW_W:0]   ny;
  logic             put_scroll;
  logic             printable;

  // Address generation.
  logic [ROW_W-1:0]  row_sel;
  logic [COL_W-1:0]  col_sel;
  logic [ROW_W:0]    phys_sum;
  logic [ROW_W:0]    phys_row;
  logic [ADDR_W-1:0] gen_addr;
  logic              rd_in_range;

  // RAM ports.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;
  logic [CELL_W-1:0] cell_val;

  assign printable = (char_r >= SPACE_CODE);

  // Cursor update for a put: control codes, printable advance, wrap, scroll.
  always_comb begin
    tab_sum    = {1'b0, cur_x_r} + (COL_W+1)'(TAB_STEP);
    nx         = {1'b0, cur_x_r};
    ny         = {1'b0, cur_y_r};
    put_scroll = 1'b0;
    priority if (char_r == TAB_CODE) begin
      nx = tab_sum & ~((COL_W+1)'(TAB_STEP - 1));
    end else if (char_r == CR_CODE) begin
      nx = '0;
    end else if (char_r == LF_CODE) begin
      nx = '0;
      ny = ny + 1'b1;
    end else if (printable) begin
      nx = nx + 1'b1;
    end else begin
      // Other control bytes leave the cursor where it is.
      nx = {1'b0, cur_x_r};
    end
    if (nx >= (COL_W+1)'(NUM_COLS)) begin
      nx = '0;
      ny = ny + 1'b1;
    end
    if (ny >= (ROW_W+1)'(NUM_ROWS)) begin
      put_scroll = 1'b1;
      nx         = '0;
      ny         = (ROW_W+1)'(NUM_ROWS - 1);
    end
  end

  assign cur_x_nxt = nx[COL_W-1:0];
  assign cur_y_nxt = ny[ROW_W-1:0];
  assign base_nxt  = (base_r == ROW_W'(NUM_ROWS - 1)) ? '0 : base_r + 1'b1;

  // Screen row and column to address: the bottom row while blanking, the
  // requested cell for a read, the cursor for a put.
  always_comb begin
    priority if (cmd.blank_wr) begin
      row_sel = ROW_W'(NUM_ROWS - 1);
      col_sel = blank_cnt_r;
    end else if (func_r == FUNC_READ) begin
      row_sel = rrow_r;
      col_sel = rcol_r;
    end else begin
      row_sel = cur_y_r;
      col_sel = cur_x_r;
    end
  end

  // Rows rotate in the store by the scroll offset.
  assign phys_sum = {1'b0, row_sel} + {1'b0, base_r};
  assign phys_row = (phys_sum >= (ROW_W+1)'(NUM_ROWS)) ?
                    phys_sum - (ROW_W+1)'(NUM_ROWS) : phys_sum;
  assign gen_addr = ADDR_W'(ADDR_W'(phys_row) * ADDR_W'(NUM_COLS)) + ADDR_W'(col_sel);

  assign rd_in_range = (rrow_r < ROW_W'(NUM_ROWS)) && (rcol_r < COL_W'(NUM_COLS));

  // Write port: clearing pass, bottom-row blanking or a printable put.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = gen_addr;
    ram_wdata = {attr, char_r};
    priority if (cmd.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = {ATTR_RESET, SPACE_CODE};
    end else if (cmd.blank_wr) begin
      ram_we    = 1'b1;
      ram_wdata = {attr, SPACE_CODE};
    end else if (cmd.exec && (func_r == FUNC_PUT) && printable) begin
      ram_we    = 1'b1;
    end else begin
      ram_we    = 1'b0;
    end
  end

  // Read port: out-of-range positions read address zero and are masked.
  assign ram_re    = cmd.exec && (func_r == FUNC_READ);
  assign ram_raddr = rd_in_range ? gen_addr : '0;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (NUM_CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cell_val = ((func_r == FUNC_READ) && rd_in_range) ? ram_rdata : '0;

  // Item capture on an input transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_tuser;
      char_r <= in_tdata[7:0];
      rrow_r <= in_tdata[12:8];
      rcol_r <= in_tdata[19:13];
    end
  end

  // Cursor, scroll offset and sweep counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      base_r      <= '0;
      scroll_r    <= 1'b0;
      clr_cnt_r   <= '0;
      blank_cnt_r <= '0;
    end else begin
      if (cmd.clear_wr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.exec) begin
        blank_cnt_r <= '0;
        if (func_r == FUNC_PUT) begin
          cur_x_r  <= cur_x_nxt;
          cur_y_r  <= cur_y_nxt;
          scroll_r <= put_scroll;
          if (put_scroll) begin
            base_r <= base_nxt;
          end
        end else begin
          scroll_r <= 1'b0;
        end
      end
      if (cmd.blank_wr) begin
        blank_cnt_r <= blank_cnt_r + 1'b1;
      end
    end
  end

  // Result register: holds a result until the transfer on the output side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {3'b000, scroll_r, cur_y_r, cur_x_r, cell_val};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Status to the controller.
  assign sts.clear_last = (clr_cnt_r == ADDR_W'(NUM_CELLS - 1));
  assign sts.blank_last = (blank_cnt_r == COL_W'(NUM_COLS - 1));
  assign sts.is_read    = (func_r == FUNC_READ);
  assign sts.scroll     = put_scroll;
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule

FILE: rtl/core/text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console with an 80x25 store of attribute/character cells, a
// cursor and an attribute register, fed by a byte stream and read by cell.
// ----------------------------------------------------------------------------
// Sequencing: an input transfer leads to EXEC and then to OUT, where the result is
// loaded once the result register is free; a put that scrolls passes through BLANK first
// (the new bottom row is blanked one cell per cycle through the single RAM write port;
// rows rotate, nothing is copied). A new item is taken only in IDLE, once the last is done.
// Reset: synchronous, active low; a clearing pass then writes 2000 blank
// cells, one per cycle, with in_tready low; configuration writes are taken.
module text_console_writer (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] char_code, [12:8] read_row, [19:13] read_col
  input  logic        in_tuser,   // [0] func
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] cell_data, [22:16] cursor_col,
                                  // [27:23] cursor_row, [28] scrolled
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tcw_pkg::*;

  tcw_cmd_t          cmd;
  tcw_sts_t          sts;
  logic [ATTR_W-1:0] attr_r;
  logic              attr_sel;

  // Attribute register at byte addresses zero to three (cfg_paddr[2] low).
  assign cfg_pready = 1'b1;
  assign attr_sel   = (cfg_paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && attr_sel) begin
      attr_r <= cfg_pwdata[ATTR_W-1:0];
    end
  end

  assign cfg_prdata = attr_sel ? {24'd0, attr_r} : '0;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .attr       (attr_r),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: tb/tb_text_console_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A mirror of the screen
// store, cursor and attribute register predicts one status report for every
// accepted input transfer, and each report that leaves the block is compared
// field by field. The run covers a directed opening, then random text lines,
// tabs, line breaks, scrolls and cell reads under several attribute settings
// and idling patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam logic [2:0] ATTR_ADDR       = 3'd0;

  // One status report as the block presents it.
  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scrolled;
  } console_report_t;

  // Mirror of the console: screen store, cursor and attribute, plus the
  // reports that are still due from the block.
  class console_mirror;
    logic [CELL_W-1:0] cells [NUM_CELLS];
    int unsigned       col;
    int unsigned       row;
    logic [ATTR_W-1:0] attr;
    console_report_t   awaited_reports [$];
    int                errors;
    int                checked;
    int                reads;
    int                scrolls;

    function new();
      attr = ATTR_RESET;
      foreach (cells[i]) cells[i] = {ATTR_RESET, SPACE_CODE};
      col = 0;
      row = 0;
    endfunction

    function void set_attribute(input logic [ATTR_W-1:0] value);
      attr = value;
    endfunction

    function int pending();
      return awaited_reports.size();
    endfunction

    // Applies one accepted item to the mirror and queues the report it causes.
    function void apply_item(input logic func, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
      console_report_t rep;
      int unsigned     i;
      rep = '0;
      if (func == FUNC_READ) begin
        reads++;
        if (rrow < NUM_ROWS && rcol < NUM_COLS) rep.cell_data = cells[rrow * NUM_COLS + rcol];
      end else begin
        if (ch == TAB_CODE) begin
          col = ((col + TAB_STEP) / TAB_STEP) * TAB_STEP;
        end else if (ch == CR_CODE) begin
          col = 0;
        end else if (ch == LF_CODE) begin
          col = 0;
          row++;
        end else if (ch >= SPACE_CODE) begin
          if (row < NUM_ROWS && col < NUM_COLS) cells[row * NUM_COLS + col] = {attr, ch};
          col++;
        end
        // Wrap past the last column.
        if (col >= NUM_COLS) begin
          col = 0;
          row++;
        end
        // Past the bottom row the screen moves up and the new row is blanked.
        if (row >= NUM_ROWS) begin
          for (i = 0; i < (NUM_ROWS - 1) * NUM_COLS; i++) cells[i] = cells[i + NUM_COLS];
          for (i = (NUM_ROWS - 1) * NUM_COLS; i < NUM_CELLS; i++) cells[i] = {attr, SPACE_CODE};
          col = 0;
          row = NUM_ROWS - 1;
          rep.scrolled = 1'b1;
          scrolls++;
        end
      end
      rep.col = COL_W'(col);
      rep.row = ROW_W'(row);
      awaited_reports.push_back(rep);
    endfunction

    function void compare_field(input string name, input logic [CELL_W-1:0] exp_v,
                                input logic [CELL_W-1:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // Compares one report from the block with the oldest one due.
    function void check_report(input logic [OUT_DATA_W-1:0] word);
      console_report_t exp_r;
      if (awaited_reports.size() == 0) begin
        $error("report 0x%0h arrived with none due", word);
        errors++;
        return;
      end
      exp_r = awaited_reports.pop_front();
      checked++;
      compare_field("cell_data", exp_r.cell_data, word[15:0]);
      compare_field("cursor_col", CELL_W'(exp_r.col), CELL_W'(word[22:16]));
      compare_field("cursor_row", CELL_W'(exp_r.row), CELL_W'(word[27:23]));
      compare_field("scrolled", CELL_W'(exp_r.scrolled), CELL_W'(word[28]));
    endfunction
  endclass

  // Block ports.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;  // [7:0] char_code, [12:8] read_row,
                                            // [19:13] read_col
  logic                  in_tuser    = 1'b0;  // [0] func
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [15:0] cell_data, [22:16] cursor_col,
                                     // [27:23] cursor_row, [28] scrolled
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [2:0]            cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Bench controls.
  console_mirror sb;
  int            gap_pct     = 0;
  int            stall_pct   = 0;
  logic          hold_off    = 1'b0;
  int            cycle_count = 0;
  int            items_in    = 0;
  int            items_left  = 0;

  text_console_writer u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // Result side: check each transfer, then choose the next ready level.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tdata);
    out_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Writes the attribute register through a setup and an access cycle.
  task automatic write_attribute(input logic [ATTR_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ATTR_ADDR;
    cfg_pwdata  <= {24'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_attribute(value);
  endtask

  // Offers one item after a random gap and waits for its transfer.
  task automatic offer_item(input logic func, input logic [CHAR_W-1:0] ch,
                            input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'h0, rcol, rrow, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.apply_item(func, ch, rrow, rcol);
    items_in++;
    // Control bytes that the block ignores do not count towards the budget.
    if (!(func == FUNC_PUT && ch < SPACE_CODE && ch != TAB_CODE && ch != CR_CODE &&
          ch != LF_CODE))
      items_left--;
  endtask

  // Stops offering and waits until every report is in, plus a tail.
  task automatic drain(input int tail);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Random traffic: mostly lines of text with line breaks, with read bursts,
  // runs of line feeds to force scrolls, and some unstructured noise.
  task automatic run_random(input int count);
    int kind;
    int len;
    int k;
    int sel;
    items_left = count;
    while (items_left > 0) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        // A line of text; long ones wrap and, on the bottom row, scroll.
        len = ($urandom_range(3) == 0) ? $urandom_range(81, 100) : $urandom_range(0, 40);
        for (k = 0; k < len && items_left > 0; k++) begin
          sel = $urandom_range(99);
          if (sel < 85)
            offer_item(FUNC_PUT, CHAR_W'($urandom_range(32, 255)), ROW_W'($urandom),
                       COL_W'($urandom));
          else if (sel < 93)
            offer_item(FUNC_PUT, TAB_CODE, ROW_W'($urandom), COL_W'($urandom));
          else if (sel < 97)
            offer_item(FUNC_PUT, CHAR_W'($urandom_range(0, 31)), ROW_W'($urandom),
                       COL_W'($urandom));
          else
            offer_item(FUNC_READ, CHAR_W'($urandom), ROW_W'(sb.row),
                       COL_W'($urandom_range(0, NUM_COLS - 1)));
        end
        sel = $urandom_range(99);
        if (sel < 40) offer_item(FUNC_PUT, CR_CODE, ROW_W'($urandom), COL_W'($urandom));
        if (sel < 70) offer_item(FUNC_PUT, LF_CODE, ROW_W'($urandom), COL_W'($urandom));
        else if (sel < 85) offer_item(FUNC_PUT, CR_CODE, ROW_W'($urandom), COL_W'($urandom));
      end else if (kind < 75) begin
        // Cell reads: half on the cursor row, most others on the screen, a few anywhere.
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          sel = $urandom_range(99);
          if (sel < 50)
            offer_item(FUNC_READ, CHAR_W'($urandom), ROW_W'(sb.row),
                       COL_W'($urandom_range(0, NUM_COLS - 1)));
          else if (sel < 90)
            offer_item(FUNC_READ, CHAR_W'($urandom), ROW_W'($urandom_range(0, NUM_ROWS - 1)),
                       COL_W'($urandom_range(0, NUM_COLS - 1)));
          else
            offer_item(FUNC_READ, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        end
      end else if (kind < 85) begin
        // Unstructured items.
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          offer_item(1'($urandom), CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      end else begin
        // A run of line feeds, long enough at times to reach the bottom.
        len = $urandom_range(1, 30);
        for (k = 0; k < len; k++)
          offer_item(FUNC_PUT, LF_CODE, ROW_W'($urandom), COL_W'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset attribute: printable extremes, each
    // control code, ignored control bytes and reads inside and outside.
    offer_item(FUNC_READ, 8'h00, 5'd0, 7'd0);
    offer_item(FUNC_PUT, 8'h41, 5'd31, 7'd127);
    offer_item(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
    offer_item(FUNC_PUT, SPACE_CODE, 5'd0, 7'd0);
    offer_item(FUNC_PUT, 8'h7F, 5'd0, 7'd0);
    offer_item(FUNC_PUT, 8'h00, 5'd0, 7'd0);
    offer_item(FUNC_PUT, 8'h1F, 5'd0, 7'd0);
    offer_item(FUNC_PUT, 8'h01, 5'd0, 7'd0);
    offer_item(FUNC_PUT, TAB_CODE, 5'd0, 7'd0);
    offer_item(FUNC_PUT, TAB_CODE, 5'd0, 7'd0);
    offer_item(FUNC_PUT, CR_CODE, 5'd0, 7'd0);
    offer_item(FUNC_PUT, LF_CODE, 5'd0, 7'd0);
    offer_item(FUNC_PUT, 8'h5A, 5'd0, 7'd0);
    offer_item(FUNC_READ, 8'hFF, 5'd0, 7'd0);
    offer_item(FUNC_READ, 8'h00, 5'd0, 7'd1);
    offer_item(FUNC_READ, 8'h00, 5'd1, 7'd0);
    offer_item(FUNC_READ, 8'h00, 5'd24, 7'd79);
    offer_item(FUNC_READ, 8'h00, 5'd31, 7'd127);
    offer_item(FUNC_READ, 8'h00, 5'd25, 7'd0);
    offer_item(FUNC_READ, 8'h00, 5'd0, 7'd80);
    offer_item(FUNC_READ, 8'h00, 5'd24, 7'd127);
    offer_item(FUNC_PUT, LF_CODE, 5'd0, 7'd0);
    drain(4);

    // Lowest attribute, no idling on either side.
    write_attribute(8'h00);
    run_random(250);
    drain(4);

    // Highest attribute, sender often idle.
    write_attribute(8'hFF);
    gap_pct = 65;
    run_random(230);
    drain(4);

    // Receiver often stalled, with one long hold-off that fills the block.
    write_attribute(ATTR_W'($urandom));
    gap_pct = 0;
    stall_pct <= 65;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_random(230);
    drain(4);

    // Light idling on both sides.
    write_attribute(ATTR_W'($urandom));
    gap_pct = 14;
    stall_pct <= 14;
    run_random(240);
    drain(100);

    $display("Covered %0d input transfers, %0d reports checked, %0d cell reads, %0d scrolls,",
             items_in, sb.checked, sb.reads, sb.scrolls);
    $display("under five attribute settings and four idling patterns with a long hold-off.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer.sv
tb/tb_text_console_writer.sv
